// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond) \
  `ASSERT_PROP(name, !(cond))

`endif

// File: hw/rtl/btmx_pkg.sv
// Package for the maximum-xor binary trie: sizes, codes and the structs
// that join controller and datapath. No dependencies.
`default_nettype none

package btmx_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 65536;

  localparam int PTR_W = $clog2(NODE_COUNT);
  localparam int ROW_W = 2 * PTR_W;
  localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  // An insert is dropped once nodes_used exceeds this.
  localparam logic [PTR_W-1:0] NODE_LIMIT = PTR_W'(NODE_COUNT - 1 - KEY_BITS);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/btmx_if.sv
// Valid/ready channel interfaces for the trie's input and result streams.
// Depends on btmx_pkg for the key width.
`default_nettype none

interface btmx_in_if import btmx_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink (input valid, input operation, input key, output ready);
endinterface

interface btmx_out_if import btmx_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] xor_result;
  logic [KEY_BITS-1:0] best_seen;
  logic                trie_empty;
  logic                insert_rejected;

  modport source (output valid, output xor_result, output best_seen,
                  output trie_empty, output insert_rejected, input ready);
  modport sink (input valid, input xor_result, input best_seen,
                input trie_empty, input insert_rejected, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/btmx_ctrl.sv
// Sequencer for the trie walk: accept, one level per cycle, deliver.
// Depends on btmx_pkg.
`default_nettype none

module btmx_ctrl import btmx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.skip) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          if (status_i.last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/btmx_dp.sv
// Datapath of the trie: child-row memory, node counter, walk registers,
// running best and the output register. Depends on btmx_pkg.
`default_nettype none

module btmx_dp import btmx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic                in_operation_i,
  input  logic [KEY_BITS-1:0] in_key_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [KEY_BITS-1:0] out_xor_result_o,
  output logic [KEY_BITS-1:0] out_best_seen_o,
  output logic                out_trie_empty_o,
  output logic                out_insert_rejected_o
);

  // One row per node: {child for bit 1, child for bit 0}, zero means absent.
  logic [ROW_W-1:0] mem [0:NODE_COUNT-1];
  logic [ROW_W-1:0] rd_q;

  op_e                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [LVL_W-1:0]    lvl_q;
  logic [PTR_W-1:0]    cur_q;
  logic                fresh_q;
  logic                skip_q;
  logic [KEY_BITS-1:0] res_q;
  logic [PTR_W-1:0]    nodes_used_q;
  logic [KEY_BITS-1:0] best_q;
  logic                has_keys_q;
  logic                out_valid_q;
  logic [KEY_BITS-1:0] out_xor_q;
  logic                out_empty_q;
  logic                out_rej_q;

  logic [ROW_W-1:0]    row_eff;
  logic [PTR_W-1:0]    half0, half1, same_child, opp_child, new_node, next_node;
  logic                key_bit, is_insert, alloc, take_opp, we, skip;
  logic [ROW_W-1:0]    wdata;
  logic [PTR_W-1:0]    raddr;
  logic [KEY_BITS-1:0] fin_res;

  always_comb begin
    // a node allocated in this walk has never had its row written
    row_eff    = fresh_q ? '0 : rd_q;
    half0      = row_eff[PTR_W-1:0];
    half1      = row_eff[ROW_W-1:PTR_W];
    key_bit    = key_q[lvl_q];
    same_child = key_bit ? half1 : half0;
    opp_child  = key_bit ? half0 : half1;
    new_node   = nodes_used_q + PTR_W'(1);
    is_insert  = (op_q == OP_INSERT);
    alloc      = (same_child == '0);
    take_opp   = (opp_child != '0);
    if (is_insert) begin
      next_node = alloc ? new_node : same_child;
    end else begin
      next_node = take_opp ? opp_child : same_child;
    end
    we      = cmd_i.step && is_insert && alloc;
    wdata   = key_bit ? {new_node, half0} : {half1, new_node};
    raddr   = cmd_i.start ? '0 : next_node;
    // decided once at accept so allocations during the walk cannot change it
    skip    = skip_q;
    if (is_insert) begin
      fin_res = '0;
    end else begin
      fin_res = skip ? key_q : res_q;
    end
  end

  assign status_o.skip     = skip;
  assign status_o.last     = (lvl_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cur_q] <= wdata;
    end
    if (cmd_i.start || cmd_i.step) begin
      rd_q <= mem[raddr];
    end
  end

  // walk registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= op_e'(in_operation_i);
      key_q   <= in_key_i;
      lvl_q   <= LVL_W'(KEY_BITS - 1);
      cur_q   <= '0;
      fresh_q <= !has_keys_q;
      skip_q  <= (op_e'(in_operation_i) == OP_INSERT) ? (nodes_used_q > NODE_LIMIT)
                                                       : !has_keys_q;
      res_q   <= '0;
    end else if (cmd_i.step) begin
      lvl_q   <= lvl_q - LVL_W'(1);
      cur_q   <= next_node;
      fresh_q <= fresh_q || (is_insert && alloc);
      res_q   <= (res_q << 1) | KEY_BITS'(take_opp);
    end
    if (cmd_i.finish) begin
      out_xor_q   <= fin_res;
      out_empty_q <= !is_insert && skip;
      out_rej_q   <= is_insert && skip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_used_q <= '0;
      best_q       <= '0;
      has_keys_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (we) begin
        nodes_used_q <= new_node;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (is_insert && !skip) begin
          has_keys_q <= 1'b1;
        end
        if (!is_insert && (fin_res > best_q)) begin
          best_q <= fin_res;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_xor_result_o      = out_xor_q;
  assign out_best_seen_o       = best_q;
  assign out_trie_empty_o      = out_empty_q;
  assign out_insert_rejected_o = out_rej_q;

endmodule

`default_nettype wire

// File: hw/rtl/binary_trie_max_xor.sv
// Maximum-xor binary trie, top level. An insert or query is accepted, walks one
// trie level per cycle (KEY_BITS = 31 levels of the child-row memory), then
// loads the output register. A new transaction is taken only once the last one
// has loaded its result; an empty-trie query or a rejected insert skips the walk.
// Reset clears the node counter, running best and flags only; the child memory needs
// no clearing pass because a fresh node or an empty trie's root reads as zero.
`default_nettype none
`include "assert_macros.svh"

module binary_trie_max_xor import btmx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  btmx_in_if.sink           in_i,
  btmx_out_if.source        out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequencer: takes a transaction in idle, steps the walk, waits for the
  // output register to free before handing over the result.
  btmx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: node rows live in a 65536 x 32 memory, node 0 is the root.
  // Insert allocates nodes from a bump counter; query prefers the opposite
  // bit at each level and shifts the xor bits into the result.
  btmx_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .in_operation_i        (in_i.operation),
    .in_key_i              (in_i.key),
    .out_ready_i           (out_o.ready),
    .out_valid_o           (out_o.valid),
    .out_xor_result_o      (out_o.xor_result),
    .out_best_seen_o       (out_o.best_seen),
    .out_trie_empty_o      (out_o.trie_empty),
    .out_insert_rejected_o (out_o.insert_rejected)
  );

  assign in_i.ready = in_ready;

  // After a transaction is taken the block is busy with it.
  `ASSERT_PROP(a_busy_after_accept, (in_i.valid && in_i.ready) |=> !in_i.ready)
  // Never load the output register while it still holds an untaken result.
  `ASSERT_NEVER(a_no_overwrite, cmd.finish && out_o.valid && !out_o.ready)
  // Any delivered xor is covered by the running best.
  `ASSERT_PROP(a_best_covers, out_o.valid |-> (out_o.xor_result <= out_o.best_seen))
  // A dropped insert reports no xor and no empty flag.
  `ASSERT_PROP(a_reject_clean,
               (out_o.valid && out_o.insert_rejected) |->
               (out_o.xor_result == '0 && !out_o.trie_empty))

endmodule

`default_nettype wire

// File: bench/binary_trie_max_xor_tb.sv
// Self-checking bench for the maximum-xor binary trie: drives insert and query
// transactions and checks every result against an in-bench trie. Depends on
// btmx_pkg, the btmx_in_if/btmx_out_if channels and binary_trie_max_xor.
`timescale 1ns / 1ps

module binary_trie_max_xor_tb;
  import btmx_pkg::*;

  localparam int STALL_PCT    = 29;    // chance of a gap on either side
  localparam int WATCH_LIMIT  = 3000;  // cycles without any transaction
  localparam int TAIL_CYCLES  = 40;    // one full walk plus margin
  localparam int RANDOM_ITEMS = 1400;
  localparam int FILL_BATCH   = 64;
  localparam int REFUSED_GOAL = 30;    // rejected inserts to collect once full
  localparam int CALM_FROM    = 40000; // cycle window with no gaps at all
  localparam int CALM_TO      = 70000;

  typedef struct {
    op_e                 op;
    logic [KEY_BITS-1:0] key;
  } trie_req_t;

  typedef struct {
    logic [KEY_BITS-1:0] xor_result;
    logic [KEY_BITS-1:0] best_seen;
    logic                trie_empty;
    logic                insert_rejected;
  } trie_result_t;

  logic clk_i;
  logic rst_ni;

  btmx_in_if  in_bus ();
  btmx_out_if out_bus ();

  binary_trie_max_xor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Stimulus waiting for the driver, and results waiting for the monitor.
  trie_req_t           queued_reqs[$];
  trie_result_t        awaited_results[$];
  logic [KEY_BITS-1:0] inserted_keys[$];

  // Shadow trie: child links, bump counter, running best and the has-keys flag.
  bit [PTR_W-1:0]      trie_links[2*NODE_COUNT];
  int unsigned         nodes_taken;
  bit [KEY_BITS-1:0]   best_xor;
  bit                  holds_keys;
  int unsigned         refused_inserts;

  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned quiet_cycles;
  bit          no_gaps;

  // Apply one transaction to the shadow trie and return the result it must give.
  function automatic trie_result_t apply_to_trie(trie_req_t req);
    trie_result_t res;
    int unsigned  node;
    int unsigned  link;
    bit           want;
    bit           take;
    bit [KEY_BITS-1:0] stored;

    res = '{default: '0};
    node = 0;
    stored = '0;
    if (req.op == OP_INSERT) begin
      // Refuse unless a whole fresh path still fits, even for a stored key.
      if (nodes_taken >= NODE_COUNT - 1 || NODE_COUNT - 1 - nodes_taken < KEY_BITS) begin
        res.insert_rejected = 1'b1;
        refused_inserts++;
      end else begin
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          link = node * 2 + req.key[lvl];
          if (trie_links[link] == 0) begin
            nodes_taken++;
            trie_links[link] = PTR_W'(nodes_taken);
          end
          node = trie_links[link];
        end
        holds_keys = 1'b1;
      end
    end else begin
      if (!holds_keys) begin
        // Empty trie: hand back the key itself and raise the flag.
        res.xor_result = req.key;
        res.trie_empty = 1'b1;
      end else begin
        // Prefer the opposite bit at every level; the path rebuilds a stored key.
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          want = !req.key[lvl];
          take = (trie_links[node * 2 + want] != 0) ? want : req.key[lvl];
          node = trie_links[node * 2 + take];
          stored[lvl] = take;
        end
        res.xor_result = stored ^ req.key;
      end
      if (res.xor_result > best_xor) best_xor = res.xor_result;
    end
    res.best_seen = best_xor;
    return res;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= 200) begin
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic queue_item(op_e op, logic [KEY_BITS-1:0] key);
    trie_req_t req;

    req.op = op;
    req.key = key;
    queued_reqs.push_back(req);
    if (op == OP_INSERT) inserted_keys.push_back(key);
  endtask

  // Hold until every queued transaction went in and every result came out.
  task automatic drain();
    while (queued_reqs.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Mix of random keys, stored keys, near neighbors of stored keys and corner patterns.
  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned         sel;
    logic [KEY_BITS-1:0] key;

    sel = $urandom_range(99);
    key = KEY_BITS'($urandom);
    if (sel >= 55 && sel < 85 && inserted_keys.size() != 0) begin
      key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      if (sel >= 70) key = key ^ (KEY_BITS'(1) << $urandom_range(KEY_BITS - 1))
                          ^ KEY_BITS'($urandom_range(255));
    end else if (sel >= 85) begin
      case ($urandom_range(5))
        0: key = '0;
        1: key = '1;
        2: key = KEY_BITS'(1) << $urandom_range(KEY_BITS - 1);
        3: key = ~(KEY_BITS'(1) << $urandom_range(KEY_BITS - 1));
        4: key = KEY_BITS'({(KEY_BITS + 1) / 2{2'b01}});
        default: key = KEY_BITS'({(KEY_BITS + 1) / 2{2'b10}});
      endcase
    end
    return key;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle count, the no-gap window and the watchdog on transaction progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      no_gaps = (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Driver: retire the accepted transaction at the rising edge, then at the
  // falling edge either hold the current one or present the next after a gap.
  always @(posedge clk_i) begin : drive_requests
    bit taken;
    bit gap;

    taken = rst_ni && in_bus.valid && in_bus.ready;
    if (taken) awaited_results.push_back(apply_to_trie(queued_reqs.pop_front()));
    @(negedge clk_i);
    if (rst_ni && (taken || !in_bus.valid)) begin
      gap = !no_gaps && ($urandom_range(99) < STALL_PCT);
      if (queued_reqs.size() != 0 && !gap) begin
        in_bus.valid     <= 1'b1;
        in_bus.operation <= queued_reqs[0].op;
        in_bus.key       <= queued_reqs[0].key;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation, field by
  // field, then pick the ready level for the next cycle.
  always @(posedge clk_i) begin : check_results
    trie_result_t want;

    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with nothing outstanding", out_bus.xor_result, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_bus.xor_result !== want.xor_result)
          flag_mismatch("xor_result", out_bus.xor_result, want.xor_result);
        if (out_bus.best_seen !== want.best_seen)
          flag_mismatch("best_seen", out_bus.best_seen, want.best_seen);
        if (out_bus.trie_empty !== want.trie_empty)
          flag_mismatch("trie_empty", out_bus.trie_empty, want.trie_empty);
        if (out_bus.insert_rejected !== want.insert_rejected)
          flag_mismatch("insert_rejected", out_bus.insert_rejected, want.insert_rejected);
      end
    end
    @(negedge clk_i);
    if (rst_ni) out_bus.ready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
  end

  initial begin : stimulus
    int unsigned       fill_idx;
    bit [11:0]         count_bits;
    bit [11:0]         spread_bits;
    logic [KEY_BITS-1:0] key;

    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_INSERT;
    in_bus.key = '0;
    out_bus.ready = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    nodes_taken = 0;
    best_xor = '0;
    holds_keys = 1'b0;
    refused_inserts = 0;
    fill_idx = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: queries on the empty trie, duplicate inserts, then queries
    // that walk the extremes and let the running best climb step by step.
    queue_item(OP_QUERY, '0);
    queue_item(OP_QUERY, KEY_BITS'(3));
    queue_item(OP_QUERY, KEY_BITS'(1));
    queue_item(OP_INSERT, '1);
    queue_item(OP_INSERT, ~KEY_BITS'(1));
    queue_item(OP_INSERT, '1);
    queue_item(OP_QUERY, '1);
    queue_item(OP_QUERY, ~KEY_BITS'(15));
    queue_item(OP_INSERT, KEY_BITS'(1) << (KEY_BITS - 1));
    queue_item(OP_QUERY, '1);
    queue_item(OP_INSERT, '0);
    queue_item(OP_INSERT, '0);
    queue_item(OP_QUERY, KEY_BITS'({(KEY_BITS + 1) / 2{2'b01}}));
    queue_item(OP_QUERY, KEY_BITS'({(KEY_BITS + 1) / 2{2'b10}}));
    queue_item(OP_QUERY, '0);
    queue_item(OP_INSERT, KEY_BITS'(1));
    queue_item(OP_QUERY, KEY_BITS'(1) << (KEY_BITS - 1));
    queue_item(OP_QUERY, '1);

    // Random mix of inserts and queries over a growing trie.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_item(($urandom_range(99) < 45) ? OP_INSERT : OP_QUERY, pick_key());
    end
    drain();

    // Fill the node pool: spread the top bits so each key takes a long fresh
    // path, mix in near neighbors that take only a few nodes so the count lands
    // close to the limit, and keep going until plenty of inserts are refused.
    while (refused_inserts < REFUSED_GOAL) begin
      for (int n = 0; n < FILL_BATCH; n++) begin
        case ($urandom_range(9))
          0: queue_item(OP_QUERY, pick_key());
          1, 2: begin
            key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            queue_item(OP_INSERT, key ^ KEY_BITS'($urandom_range(1, 255)));
          end
          3: queue_item(OP_INSERT, inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
          default: begin
            count_bits = fill_idx[11:0];
            spread_bits = {<<{count_bits}};
            key = KEY_BITS'($urandom);
            key[KEY_BITS-1 -: 12] = spread_bits;
            queue_item(OP_INSERT, key);
            fill_idx++;
          end
        endcase
      end
      drain();
    end

    // Full trie: a stored key and the extremes are refused; queries still answer.
    queue_item(OP_INSERT, '0);
    queue_item(OP_INSERT, '1);
    queue_item(OP_QUERY, '0);
    queue_item(OP_QUERY, '1);
    queue_item(OP_QUERY, pick_key());
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
